// ===== rtl/fmsd_pkg.sv =====
// Shared types and constants for the frame motion and scene detector.
package fmsd_pkg;

  // Default sample memory depth
  localparam int unsigned MAX_SAMPLES_DEF = 4096;

  // Result field widths
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned SCORE_W = 17;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned FRAME_W = 32;

  // Fraction bits of the motion score
  localparam int unsigned FRAC_BITS = 16;

  // djb2 seed
  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

  // Register reset values
  localparam logic [7:0]  THRESH_RST  = 8'd30;
  localparam logic [15:0] HSTRIDE_RST = 16'd1000;
  localparam logic [15:0] MSTRIDE_RST = 16'd100;

  // Register map, one 32-bit word each
  localparam int unsigned CFG_ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_THRESH  = 2'd0,
    REG_HSTRIDE = 2'd1,
    REG_MSTRIDE = 2'd2
  } reg_idx_t;

  // Frame-end result sequencer
  typedef enum logic [1:0] {
    RS_IDLE,
    RS_DIV,
    RS_DONE
  } rs_state_t;

endpackage

// ===== rtl/frame_motion_scene_detect.sv =====
// Top level: byte-stream scene hash and sample-memory motion detector.
//
// Frame bytes arrive one beat per cycle while in_stall is low. Every
// hash-stride byte is folded into a 64-bit djb2 hash; every motion-stride
// byte is read from, compared against and written back to a MAX_SAMPLES x 8
// sample memory (one read port, one write port, registered read). Bytes are
// taken at one per cycle unless stalled. After the byte flagged frame_last
// the input stalls while the last sample is written back and the frame
// totals are latched, then while a one-bit-per-cycle restoring divider
// forms the motion score (16 fraction steps); when the score is forced to
// zero the divider is skipped.
// The result sits in an output register, and bytes of the next frame are
// taken while it waits; only a further frame end stalls until the pending
// result is taken.
// The sample memory needs no clearing pass: only positions written by the
// previous frame are compared.
module frame_motion_scene_detect #(
  parameter int unsigned MAX_SAMPLES = fmsd_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_pixel_byte,
  input  logic                                in_frame_last,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fmsd_pkg::HASH_W-1:0]         out_digest,
  output logic                                out_hash_changed,
  output logic [fmsd_pkg::SCORE_W-1:0]        out_activity,
  output logic [fmsd_pkg::COUNT_W-1:0]        out_changed_samples,
  output logic [fmsd_pkg::COUNT_W-1:0]        out_compared_samples,
  output logic                                out_first_frame,
  output logic [fmsd_pkg::FRAME_W-1:0]        out_frame_seq,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fmsd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import fmsd_pkg::*;

  localparam int unsigned AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned STEP_W = $clog2(FRAC_BITS);

  // ---------------------------------------------------------------- config
  logic [7:0]  thresh_r;
  logic [15:0] hstride_r;
  logic [15:0] mstride_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RST;
      hstride_r <= HSTRIDE_RST;
      mstride_r <= MSTRIDE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESH:  thresh_r  <= pwdata[7:0];
        REG_HSTRIDE: hstride_r <= pwdata[15:0];
        REG_MSTRIDE: mstride_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESH:  prdata = {24'd0, thresh_r};
      REG_HSTRIDE: prdata = {16'd0, hstride_r};
      REG_MSTRIDE: prdata = {16'd0, mstride_r};
      default:     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- state
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [15:0]        hcnt_r, hcnt_nxt;
  logic [15:0]        mcnt_r, mcnt_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      changed_r, changed_nxt;
  logic [CW-1:0]      prev_cnt_r;
  logic [HASH_W-1:0]  prev_hash_r;
  logic               have_prev_r;
  logic [FRAME_W-1:0] frame_cnt_r;

  // stage 1 pipe: sample read issued, compare and write back next cycle
  logic               s1_valid_r;
  logic               s1_last_r;
  logic               s1_wr_r;
  logic               s1_cmp_r;
  logic [AW-1:0]      s1_addr_r;
  logic [7:0]         s1_byte_r;

  rs_state_t          rs_state_r, rs_state_nxt;

  logic               in_acc;
  logic               take_hash;
  logic               take_sample;
  logic               sample_keep;
  logic               s1_end;

  // stall for the write-back cycle of a frame end and while a result forms or waits for the output register
  assign in_stall = (s1_valid_r & s1_last_r) | (rs_state_r != RS_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign s1_end   = s1_valid_r & s1_last_r;

  assign take_hash   = (hcnt_r == 16'd0);
  assign take_sample = (mcnt_r == 16'd0);
  assign sample_keep = take_sample & (pos_r < CW'(MAX_SAMPLES));

  // ---------------------------------------------------------------- memory
  logic [7:0] sample_mem [MAX_SAMPLES];
  logic [7:0] rd_r;

  always_ff @(posedge clk) begin
    if (in_acc && sample_keep) begin
      rd_r <= sample_mem[pos_r[AW-1:0]];
    end
    if (s1_valid_r && s1_wr_r) begin
      sample_mem[s1_addr_r] <= s1_byte_r;
    end
  end

  // ---------------------------------------------------------------- compare
  logic [7:0]    abs_diff;
  logic          is_changed;
  logic [CW-1:0] changed_sum;

  assign abs_diff   = (s1_byte_r > rd_r) ? (s1_byte_r - rd_r) : (rd_r - s1_byte_r);
  assign is_changed = s1_valid_r & s1_wr_r & s1_cmp_r & (abs_diff > thresh_r);
  // running count including the sample in stage 1
  assign changed_sum = changed_r + CW'(is_changed);

  // ---------------------------------------------------------------- per-frame next
  always_comb begin
    hash_nxt    = hash_r;
    hcnt_nxt    = hcnt_r;
    mcnt_nxt    = mcnt_r;
    pos_nxt     = pos_r;
    changed_nxt = changed_sum;
    if (in_acc) begin
      if (take_hash) begin
        hash_nxt = (hash_r << 5) + hash_r + HASH_W'(in_pixel_byte);
        hcnt_nxt = (hstride_r == 16'd0) ? 16'd0 : hstride_r - 16'd1;
      end else begin
        hcnt_nxt = hcnt_r - 16'd1;
      end
      if (take_sample) begin
        mcnt_nxt = (mstride_r == 16'd0) ? 16'd0 : mstride_r - 16'd1;
      end else begin
        mcnt_nxt = mcnt_r - 16'd1;
      end
      if (sample_keep) begin
        pos_nxt = pos_r + CW'(1);
      end
    end
    // restart once the flagged byte has been written back
    if (s1_end) begin
      hash_nxt    = HASH_SEED;
      hcnt_nxt    = 16'd0;
      mcnt_nxt    = 16'd0;
      pos_nxt     = '0;
      changed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r    <= HASH_SEED;
      hcnt_r    <= 16'd0;
      mcnt_r    <= 16'd0;
      pos_r     <= '0;
      changed_r <= '0;
    end else begin
      hash_r    <= hash_nxt;
      hcnt_r    <= hcnt_nxt;
      mcnt_r    <= mcnt_nxt;
      pos_r     <= pos_nxt;
      changed_r <= changed_nxt;
    end
  end

  // stage 1 pipe register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s1_wr_r    <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s1_last_r  <= in_frame_last;
      s1_wr_r    <= sample_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmp_r  <= have_prev_r & (pos_r < prev_cnt_r);
      s1_addr_r <= pos_r[AW-1:0];
      s1_byte_r <= in_pixel_byte;
    end
  end

  // ---------------------------------------------------------------- frame totals
  logic [CW-1:0] compared;
  logic          zero_score;

  always_comb begin
    if (!have_prev_r) begin
      compared = '0;
    end else if (pos_r < prev_cnt_r) begin
      compared = pos_r;
    end else begin
      compared = prev_cnt_r;
    end
  end
  assign zero_score = ~have_prev_r | (compared == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cnt_r  <= '0;
      prev_hash_r <= '0;
      have_prev_r <= 1'b0;
      frame_cnt_r <= '0;
    end else if (s1_end) begin
      prev_cnt_r  <= pos_r;
      prev_hash_r <= hash_r;
      have_prev_r <= 1'b1;
      frame_cnt_r <= frame_cnt_r + FRAME_W'(1);
    end
  end

  // latched result fields
  logic [HASH_W-1:0]  res_hash_r;
  logic               res_changed_scene_r;
  logic [CW-1:0]      res_changed_r;
  logic [CW-1:0]      res_compared_r;
  logic               res_first_r;
  logic [FRAME_W-1:0] res_frame_r;

  always_ff @(posedge clk) begin
    if (s1_end) begin
      res_hash_r          <= hash_r;
      res_changed_scene_r <= ~have_prev_r | (hash_r != prev_hash_r);
      res_changed_r       <= changed_sum;
      res_compared_r      <= compared;
      res_first_r         <= ~have_prev_r;
      res_frame_r         <= frame_cnt_r;
    end
  end

  // ---------------------------------------------------------------- divider
  // score = changed * 2^16 / compared; changed <= compared, so the integer
  // part is one bit and the remainder stays below the divisor.
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [CW-1:0]      dvs_r;
  logic [SCORE_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [CW:0]        rem_sh;
  logic               int_bit;
  logic               div_step;
  logic               div_last;
  logic               res_emit;
  logic               out_free;

  assign int_bit  = (changed_sum >= compared);
  assign rem_sh   = {rem_r, 1'b0};
  assign div_last = (step_r == STEP_W'(FRAC_BITS - 1));
  assign out_free = ~out_valid | ~out_stall;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (s1_end) begin
      rem_nxt = int_bit ? (changed_sum - compared) : changed_sum;
      quo_nxt = zero_score ? '0 : SCORE_W'(int_bit);
    end else if (div_step) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = CW'(rem_sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[SCORE_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CW-1:0];
        quo_nxt = {quo_r[SCORE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (s1_end) begin
      dvs_r <= compared;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (s1_end) begin
      step_r <= '0;
    end else if (div_step) begin
      step_r <= step_r + STEP_W'(1);
    end
  end

  // sequencer next state
  always_comb begin
    rs_state_nxt = rs_state_r;
    case (rs_state_r)
      RS_IDLE: begin
        if (s1_end) begin
          rs_state_nxt = zero_score ? RS_DONE : RS_DIV;
        end
      end
      RS_DIV: begin
        if (div_last) begin
          rs_state_nxt = RS_DONE;
        end
      end
      RS_DONE: begin
        if (out_free) begin
          rs_state_nxt = RS_IDLE;
        end
      end
      default: rs_state_nxt = RS_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_step = 1'b0;
    res_emit = 1'b0;
    case (rs_state_r)
      RS_DIV:  div_step = 1'b1;
      RS_DONE: res_emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_state_r <= RS_IDLE;
    end else begin
      rs_state_r <= rs_state_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_emit) begin
      out_digest           <= res_hash_r;
      out_hash_changed     <= res_changed_scene_r;
      out_activity         <= quo_r;
      out_changed_samples  <= COUNT_W'(res_changed_r);
      out_compared_samples <= COUNT_W'(res_compared_r);
      out_first_frame      <= res_first_r;
      out_frame_seq        <= res_frame_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
